// ----- src/tps_pkg.sv -----
// Shared types and codes for the template pulse superposition block.
`default_nettype none
package tps_pkg;

	typedef enum logic [1:0] {
		KIND_TEMPLATE = 2'd0,
		KIND_PULSE    = 2'd1,
		KIND_CLEAR    = 2'd2,
		KIND_COMPUTE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FIN
	} state_t;

	typedef enum logic {
		CFG_BASELINE = 1'b0,
		CFG_TLEN     = 1'b1
	} cfg_idx_t;

	localparam int CFG_DATA_W = 16;
	localparam int FIT_W      = 20;

endpackage
`default_nettype wire

// ----- src/tps_if.sv -----
// Item and result channel interfaces.
`default_nettype none
interface tps_in_if;
	logic                valid;
	logic                ready;
	tps_pkg::kind_t      kind;
	logic [11:0]         position;
	logic signed [15:0]  template_word;
	logic signed [12:0]  pulse_start;
	logic signed [15:0]  pulse_amplitude;

	modport source (output valid, kind, position, template_word, pulse_start,
		pulse_amplitude, input ready);
	modport sink (input valid, kind, position, template_word, pulse_start,
		pulse_amplitude, output ready);
endinterface

interface tps_out_if;
	logic                valid;
	logic                ready;
	logic [11:0]         sample_pos;
	logic signed [19:0]  fit_value;
	logic                saturated;
	logic                pulses_dropped;

	modport source (output valid, sample_pos, fit_value, saturated, pulses_dropped,
		input ready);
	modport sink (input valid, sample_pos, fit_value, saturated, pulses_dropped,
		output ready);
endinterface
`default_nettype wire

// ----- src/template_pulse_superposition.sv -----
// Compute item: the stored pulses are walked through the pulse data, template data and
// product stages into the accumulator; one pulse memory read per cycle sets the walk rate.
// Input is closed during a compute; it reopens in the cycle after the result loads.
// Template, pulse and clear items do not close the input.
// A result waits in an output register while the next item is taken.
// Reset clears pulse count and drop flag, sets baseline to 0 and template length to 256; memories are not cleared.
`default_nettype none
module template_pulse_superposition #(
	parameter int TEMPLATE_DEPTH = 256,
	parameter int MAX_PULSES     = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire tps_pkg::cfg_idx_t             cfg_index,
	input  wire logic [tps_pkg::CFG_DATA_W-1:0] cfg_data,
	tps_in_if.sink                             in_ch,
	tps_out_if.source                          out_ch
);
	import tps_pkg::*;

	localparam int TAW    = (TEMPLATE_DEPTH > 1) ? $clog2(TEMPLATE_DEPTH) : 1;
	localparam int PAW    = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
	localparam int PCW    = $clog2(MAX_PULSES + 1);
	localparam int PW     = 29;
	localparam int ACC_W  = 33 + $clog2(MAX_PULSES + 1);
	localparam int RW     = ACC_W - 15;
	localparam logic signed [RW-1:0] R_MAX = RW'(524287);
	localparam logic signed [RW-1:0] R_MIN = -RW'(524288);

	// config
	logic signed [15:0] base_q;
	logic [8:0]         tlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			tlen_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASELINE: base_q <= $signed(cfg_data);
				CFG_TLEN:     tlen_q <= cfg_data[8:0];
				default:      ;
			endcase
		end
	end

	state_t state_q, state_d;
	logic   in_xfer, take_compute, issue, load, pipe_busy;
	logic [PCW-1:0] cnt_q, k_q;
	logic   drop_q;

	assign in_xfer      = in_ch.valid && in_ch.ready;
	assign take_compute = in_xfer && (in_ch.kind == KIND_COMPUTE);

	// memories
	logic           tw_we;
	logic [TAW-1:0] t_raddr;
	logic [15:0]    t_rdata;
	logic           pw_we;
	logic [PW-1:0]  p_rdata;

	assign tw_we = in_xfer && (in_ch.kind == KIND_TEMPLATE)
		&& ({1'b0, in_ch.position} < 13'(TEMPLATE_DEPTH));
	assign pw_we = in_xfer && (in_ch.kind == KIND_PULSE) && (cnt_q < PCW'(MAX_PULSES));

	tps_ram #(.WIDTH(16), .DEPTH(TEMPLATE_DEPTH)) u_tmpl (
		.clk   (clk),
		.we    (tw_we),
		.waddr (in_ch.position[TAW-1:0]),
		.wdata (in_ch.template_word),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	tps_ram #(.WIDTH(PW), .DEPTH(MAX_PULSES)) u_pulse (
		.clk   (clk),
		.we    (pw_we),
		.waddr (cnt_q[PAW-1:0]),
		.wdata ({in_ch.pulse_start, in_ch.pulse_amplitude}),
		.raddr (k_q[PAW-1:0]),
		.rdata (p_rdata)
	);

	// pulse table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else if (in_xfer) begin
			case (in_ch.kind)
				KIND_PULSE: begin
					if (cnt_q < PCW'(MAX_PULSES)) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						drop_q <= 1'b1;
					end
				end
				KIND_CLEAR: begin
					cnt_q  <= '0;
					drop_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (take_compute) state_d = ST_WALK;
			ST_WALK:  if (!issue) state_d = ST_DRAIN;
			ST_DRAIN: if (!pipe_busy) state_d = ST_FIN;
			ST_FIN:   if (load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		issue       = (state_q == ST_WALK) && (k_q < cnt_q);
		load        = (state_q == ST_FIN) && (!out_ch.valid || out_ch.ready);
	end

	// walk pipeline: s1 pulse data, s2 template data, s3 product
	logic [11:0]        pos_q;
	logic               v_s1, v_s2, v_s3;
	logic signed [15:0] gain_s2;
	logic               hit_s2;
	logic signed [31:0] prod_s3;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [13:0] j_off;
	logic [13:0]        len_eff;
	logic               hit;

	assign pipe_busy = v_s1 || v_s2 || v_s3;
	assign len_eff   = (14'(tlen_q) > 14'(TEMPLATE_DEPTH)) ? 14'(TEMPLATE_DEPTH) : 14'(tlen_q);
	assign j_off     = $signed({2'b00, pos_q}) - $signed({p_rdata[PW-1], p_rdata[PW-1:16]});
	assign hit       = !j_off[13] && (j_off < $signed(len_eff));
	assign t_raddr   = j_off[TAW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (take_compute) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take_compute) begin
			pos_q <= in_ch.position;
			acc_q <= {{(ACC_W-31){base_q[15]}}, base_q, 15'b0};
		end else if (v_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end
		gain_s2 <= $signed(p_rdata[15:0]);
		hit_s2  <= hit;
		prod_s3 <= hit_s2 ? gain_s2 * $signed(t_rdata) : 32'sd0;
	end

	// round half up, then clip to 20 bits
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [RW-1:0]    rnd;
	logic                    sat_hi, sat_lo;

	assign acc_rnd = acc_q + ACC_W'(16384);
	assign rnd     = acc_rnd[ACC_W-1:15];
	assign sat_hi  = rnd > R_MAX;
	assign sat_lo  = rnd < R_MIN;

	logic                    out_v_q;
	logic [11:0]             out_idx_q;
	logic signed [FIT_W-1:0] out_fit_q;
	logic                    out_sat_q;
	logic                    out_drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_idx_q  <= pos_q;
			out_fit_q  <= sat_hi ? R_MAX[FIT_W-1:0] : sat_lo ? R_MIN[FIT_W-1:0] : rnd[FIT_W-1:0];
			out_sat_q  <= sat_hi || sat_lo;
			out_drop_q <= drop_q;
		end
	end

	assign out_ch.valid          = out_v_q;
	assign out_ch.sample_pos     = out_idx_q;
	assign out_ch.fit_value      = out_fit_q;
	assign out_ch.saturated      = out_sat_q;
	assign out_ch.pulses_dropped = out_drop_q;

	// checks
	a_drop_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drop_q) |-> $past(cnt_q == PCW'(MAX_PULSES)))
		else $error("drop flag set while pulse table had room");

	a_ready_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !pipe_busy)
		else $error("item taken while pulse walk still in flight");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(state_q == ST_FIN))
		else $error("result loaded outside final state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (in_ch.kind == KIND_PULSE) |=> cnt_q <= PCW'(MAX_PULSES))
		else $error("pulse count beyond table size");

endmodule
`default_nettype wire

// ----- src/tps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
